// ----- hdl/gps_lap_gate_detector_assert.svh -----
// Assertion macros shared by the gate detector RTL.
`ifndef GPS_LAP_GATE_DETECTOR_ASSERT_SVH
`define GPS_LAP_GATE_DETECTOR_ASSERT_SVH
`ifndef SYNTH
// cond implies conseq in the same cycle
`define GLGD_ASSERT_IMP(lbl, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("%m: same-cycle check failed");
// cond implies conseq in the next cycle
`define GLGD_ASSERT_NXT(lbl, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("%m: next-cycle check failed");
`else
`define GLGD_ASSERT_IMP(lbl, cond, conseq)
`define GLGD_ASSERT_NXT(lbl, cond, conseq)
`endif
`endif

// ----- hdl/glgd_pkg.sv -----
// Shared constants, register indexes and interface structs of the gate detector.
package glgd_pkg;

    localparam int LAP_COUNT_BITS = 16;
    localparam int TIMER_BITS     = 32;

    // serial multiply-accumulate geometry
    localparam int MUL_STEPS = 32;
    localparam int CNT_W     = $clog2(MUL_STEPS);
    localparam int OPD_W     = 43;
    localparam int ACC_W     = 46;
    localparam int POS_W     = 46;

    localparam logic [MUL_STEPS-1:0] NORTH_SCALE = 32'd11952773;
    localparam logic [15:0]          COURSE_MOD  = 16'd36000;
    localparam logic signed [16:0]   HEADING_TOL = 17'sd8000;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_HOME_LAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_LON  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_HDG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EAST_SCL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_COS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POS_TOL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LAP   = 3'd7;

    localparam logic [23:0]        EAST_SCALE_RST = 24'd11952773;
    localparam logic signed [31:0] ROT_COS_RST    = 32'sd1073741824;
    localparam logic [30:0]        POS_TOL_RST    = 31'd524288;
    localparam logic [31:0]        MIN_LAP_RST    = 32'd10;

    typedef struct packed {
        logic start;
        logic sub;
    } glgd_mac_cmd_t;

    typedef struct packed {
        logic commit;
        logic tick;
        logic near;
    } glgd_lap_cmd_t;

    typedef struct packed {
        logic        lap_completed;
        logic [15:0] lap_count;
        logic [31:0] last_lap_ticks;
        logic [31:0] elapsed_ticks;
    } glgd_result_t;

endpackage

// ----- hdl/glgd_mac.sv -----
// Bit-serial multiply-accumulate unit: hi:lo = a*ma + b*mb (or minus b*mb).
`include "gps_lap_gate_detector_assert.svh"
module glgd_mac
    import glgd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  glgd_mac_cmd_t               cmd,
    input  logic signed [OPD_W-1:0]     a,
    input  logic signed [OPD_W-1:0]     b,
    input  logic        [MUL_STEPS-1:0] ma,
    input  logic        [MUL_STEPS-1:0] mb,
    output logic                        busy,
    output logic signed [ACC_W-1:0]     hi,
    output logic        [MUL_STEPS-1:0] lo
);

    logic                        busy_reg, busy_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic signed [OPD_W-1:0]     a_reg, b_reg;
    logic [MUL_STEPS-1:0]        ma_reg, mb_reg;
    logic                        sub_reg;
    logic signed [ACC_W-1:0]     hi_reg;
    logic [MUL_STEPS-1:0]        lo_reg;

    logic                        last;
    logic signed [ACC_W-1:0]     a_ext, b_ext, ta, tb, sum;

    assign last  = (cnt_reg == CNT_W'(MUL_STEPS - 1));
    assign a_ext = {{(ACC_W-OPD_W){a_reg[OPD_W-1]}}, a_reg};
    assign b_ext = {{(ACC_W-OPD_W){b_reg[OPD_W-1]}}, b_reg};

    // top multiplier bit carries negative weight
    always_comb
    begin
        ta = ma_reg[0] ? a_ext : '0;
        if (last)
        begin
            ta = -ta;
        end
        tb = mb_reg[0] ? b_ext : '0;
        if (last ^ sub_reg)
        begin
            tb = -tb;
        end
        sum = hi_reg + ta + tb;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            if (last)
            begin
                busy_next = 1'b0;
                cnt_next  = '0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // shift right: dropped bits collect in lo, hi stays floored
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            ma_reg  <= ma;
            mb_reg  <= mb;
            sub_reg <= cmd.sub;
            hi_reg  <= '0;
            lo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[ACC_W-1], sum[ACC_W-1:1]};
            lo_reg <= {sum[0], lo_reg[MUL_STEPS-1:1]};
            ma_reg <= {1'b0, ma_reg[MUL_STEPS-1:1]};
            mb_reg <= {1'b0, mb_reg[MUL_STEPS-1:1]};
        end
    end

    assign busy = busy_reg;
    assign hi   = hi_reg;
    assign lo   = lo_reg;

    `GLGD_ASSERT_IMP(a_idle_cnt_zero, !busy_reg, cnt_reg == '0)
    `GLGD_ASSERT_NXT(a_start_busy, cmd.start, busy_reg && (cnt_reg == '0))
    `GLGD_ASSERT_NXT(a_last_done, busy_reg && last && !cmd.start, !busy_reg)

endmodule

// ----- hdl/glgd_lap.sv -----
// Lap bookkeeping: tick timer, lap counter, last lap time and result word.
module glgd_lap
    import glgd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  glgd_lap_cmd_t cmd,
    input  logic [31:0]   min_lap_ticks,
    output glgd_result_t  result
);

    logic [TIMER_BITS-1:0]     timer_reg, timer_next;
    logic [LAP_COUNT_BITS-1:0] laps_reg, laps_next;
    logic [31:0]               last_reg, last_next;
    logic                      done;
    logic [63:0]               timer_ext, min_ext;
    logic [31:0]               laps_ext;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v[63:32] != '0) ? '1 : v[31:0];
    endfunction

    assign timer_ext = 64'(timer_reg);
    assign min_ext   = 64'(min_lap_ticks);

    always_comb
    begin
        timer_next = timer_reg;
        laps_next  = laps_reg;
        last_next  = last_reg;
        done       = 1'b0;
        if (cmd.tick)
        begin
            if (timer_reg != '1)
            begin
                timer_next = TIMER_BITS'(timer_reg + 1'b1);
            end
        end
        else if (cmd.near)
        begin
            // near home: clear timer, count a lap only if long enough
            timer_next = '0;
            if (timer_ext >= min_ext)
            begin
                done      = 1'b1;
                last_next = sat32(timer_ext);
                if (laps_reg != '1)
                begin
                    laps_next = LAP_COUNT_BITS'(laps_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
            laps_reg  <= '0;
            last_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            timer_reg <= timer_next;
            laps_reg  <= laps_next;
            last_reg  <= last_next;
        end
    end

    assign laps_ext = 32'(laps_next);

    always_comb
    begin
        result.lap_completed  = done;
        result.lap_count      = (laps_ext[31:16] != '0) ? 16'hFFFF : laps_ext[15:0];
        result.last_lap_ticks = last_next;
        result.elapsed_ticks  = sat32(64'(timer_next));
    end

endmodule

// ----- hdl/gps_lap_gate_detector.sv -----
// Top level of the GPS lap gate detector: config registers, sequencer, output register.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one word per fix or tick: action 0 is a
//   GPS fix (latitude, longitude, course), action 1 is one time tick.
//   Output channel (out_valid/out_stall) returns exactly one result word per input
//   word, in order: lap flag, lap count, last lap duration and elapsed ticks.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data); write it
//   only while the block is idle.
// Sequencing:
//   A tick goes straight to the commit step once accepted. A fix makes one pass through
//   the bit-serial multiply-accumulate units (projection to metres), then a step to
//   start the second pass (rotation), the second pass, a compare step and a commit step.
//   One word is in flight at a time; the next word is accepted the cycle after the
//   previous result is loaded into the output register.
// Reset: rst_n clears the lap count, timer and last lap time, restores the default
//   configuration and empties the output register.
// Stall: while out_stall holds a result, a finished word waits in the commit step
//   and no further input is taken until the output register frees up.
module gps_lap_gate_detector
    import glgd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic signed [30:0]    latitude,
    input  logic signed [31:0]    longitude,
    input  logic [15:0]           course,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  lap_completed,
    output logic [15:0]           lap_count,
    output logic [31:0]           last_lap_ticks,
    output logic [31:0]           elapsed_ticks
);

    `include "gps_lap_gate_detector_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL1 = 4'b0010,
        S_MUL2 = 4'b0100,
        S_FIN  = 4'b1000
    } glgd_state_t;

    glgd_state_t state_reg, state_next;

    // configuration registers
    logic signed [30:0] home_lat_reg;
    logic signed [31:0] home_lon_reg;
    logic [15:0]        home_hdg_reg;
    logic [23:0]        east_scale_reg;
    logic signed [31:0] rot_cos_reg;
    logic signed [31:0] rot_sin_reg;
    logic [30:0]        pos_tol_reg;
    logic [31:0]        min_lap_reg;

    // per-word working registers
    logic is_tick_reg;
    logic heading_ok_reg;
    logic near_reg;

    // output register
    logic        out_valid_reg;
    logic        lap_completed_reg;
    logic [15:0] lap_count_reg;
    logic [31:0] last_lap_reg;
    logic [31:0] elapsed_reg;

    logic accept, units_idle, slot_free, commit;

    glgd_mac_cmd_t                mac_cmd0, mac_cmd1;
    logic signed [OPD_W-1:0]      a0, b0, a1, b1;
    logic        [MUL_STEPS-1:0]  ma0, mb0, ma1, mb1;
    logic                         busy0, busy1;
    logic signed [ACC_W-1:0]      hi0, hi1;
    logic        [MUL_STEPS-1:0]  lo0, lo1;

    logic signed [32:0]      dlon;
    logic signed [31:0]      dlat;
    logic signed [OPD_W-1:0] x_pos, y_pos;
    logic signed [POS_W-1:0] rx, ry;
    logic [POS_W-1:0]        rx_abs, ry_abs, tol_ext;
    logic                    pos_ok;
    logic [15:0]             course_mod;
    logic signed [16:0]      hdg_diff;
    logic                    heading_ok;

    glgd_lap_cmd_t lap_cmd;
    glgd_result_t  lap_result;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign units_idle = !busy0 && !busy1;
    assign slot_free  = !out_valid_reg || !out_stall;
    assign commit     = (state_reg == S_FIN) && slot_free;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_lat_reg   <= '0;
            home_lon_reg   <= '0;
            home_hdg_reg   <= '0;
            east_scale_reg <= EAST_SCALE_RST;
            rot_cos_reg    <= ROT_COS_RST;
            rot_sin_reg    <= '0;
            pos_tol_reg    <= POS_TOL_RST;
            min_lap_reg    <= MIN_LAP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HOME_LAT: home_lat_reg   <= cfg_data[30:0];
                REG_HOME_LON: home_lon_reg   <= cfg_data[31:0];
                REG_HOME_HDG: home_hdg_reg   <= cfg_data[15:0];
                REG_EAST_SCL: east_scale_reg <= cfg_data[23:0];
                REG_ROT_COS:  rot_cos_reg    <= cfg_data[31:0];
                REG_ROT_SIN:  rot_sin_reg    <= cfg_data[31:0];
                REG_POS_TOL:  pos_tol_reg    <= cfg_data[30:0];
                REG_MIN_LAP:  min_lap_reg    <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // offsets from home, exact
    assign dlon = {longitude[31], longitude} - {home_lon_reg[31], home_lon_reg};
    assign dlat = {latitude[30], latitude} - {home_lat_reg[30], home_lat_reg};

    // heading window: course folded once into 0..35999, no wrap against home
    assign course_mod = (course >= COURSE_MOD) ? 16'(course - COURSE_MOD) : course;
    assign hdg_diff   = $signed({1'b0, course_mod}) - $signed({1'b0, home_hdg_reg});
    assign heading_ok = (hdg_diff <= HEADING_TOL) && (hdg_diff >= -HEADING_TOL);

    // metres Q27.16 after the first pass: floor(product / 2^14)
    assign x_pos = {hi0[OPD_W-MUL_STEPS+13:0], lo0[MUL_STEPS-1:14]};
    assign y_pos = {hi1[OPD_W-MUL_STEPS+13:0], lo1[MUL_STEPS-1:14]};

    // rotated position after the second pass: floor(sum / 2^30)
    assign rx = {hi0[POS_W-3:0], lo0[MUL_STEPS-1:MUL_STEPS-2]};
    assign ry = {hi1[POS_W-3:0], lo1[MUL_STEPS-1:MUL_STEPS-2]};

    assign rx_abs  = rx[POS_W-1] ? POS_W'(-rx) : POS_W'(rx);
    assign ry_abs  = ry[POS_W-1] ? POS_W'(-ry) : POS_W'(ry);
    assign tol_ext = POS_W'(pos_tol_reg);
    assign pos_ok  = (rx_abs <= tol_ext) && (ry_abs <= tol_ext);

    // unit 0: east offset, then x*cos + y*sin
    // unit 1: north offset, then y*cos - x*sin
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            a0  = {{(OPD_W-33){dlon[32]}}, dlon};
            b0  = '0;
            ma0 = MUL_STEPS'(east_scale_reg);
            mb0 = '0;
            a1  = {{(OPD_W-32){dlat[31]}}, dlat};
            b1  = '0;
            ma1 = NORTH_SCALE;
            mb1 = '0;
        end
        else
        begin
            a0  = x_pos;
            b0  = y_pos;
            ma0 = rot_cos_reg;
            mb0 = rot_sin_reg;
            a1  = y_pos;
            b1  = x_pos;
            ma1 = rot_cos_reg;
            mb1 = rot_sin_reg;
        end
    end

    always_comb
    begin
        mac_cmd0.start = (accept && !action) || ((state_reg == S_MUL1) && units_idle);
        mac_cmd0.sub   = 1'b0;
        mac_cmd1.start = mac_cmd0.start;
        mac_cmd1.sub   = (state_reg == S_MUL1);
    end

    glgd_mac u_mac0 (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd0),
        .a     (a0),
        .b     (b0),
        .ma    (ma0),
        .mb    (mb0),
        .busy  (busy0),
        .hi    (hi0),
        .lo    (lo0)
    );

    glgd_mac u_mac1 (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd1),
        .a     (a1),
        .b     (b1),
        .ma    (ma1),
        .mb    (mb1),
        .busy  (busy1),
        .hi    (hi1),
        .lo    (lo1)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = action ? S_FIN : S_MUL1;
                end
            end
            S_MUL1:
            begin
                if (units_idle)
                begin
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (units_idle)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // capture word kind and heading at accept, position verdict after rotation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_tick_reg    <= action;
            heading_ok_reg <= heading_ok;
        end
        if ((state_reg == S_MUL2) && units_idle)
        begin
            near_reg <= pos_ok && heading_ok_reg;
        end
    end

    always_comb
    begin
        lap_cmd.commit = commit;
        lap_cmd.tick   = is_tick_reg;
        lap_cmd.near   = near_reg;
    end

    glgd_lap u_lap (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (lap_cmd),
        .min_lap_ticks (min_lap_reg),
        .result        (lap_result)
    );

    // output register: load on commit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            lap_completed_reg <= lap_result.lap_completed;
            lap_count_reg     <= lap_result.lap_count;
            last_lap_reg      <= lap_result.last_lap_ticks;
            elapsed_reg       <= lap_result.elapsed_ticks;
        end
    end

    assign out_valid      = out_valid_reg;
    assign lap_completed  = lap_completed_reg;
    assign lap_count      = lap_count_reg;
    assign last_lap_ticks = last_lap_reg;
    assign elapsed_ticks  = elapsed_reg;

    `GLGD_ASSERT_IMP(a_accept_idle, in_valid && !in_stall, state_reg == S_IDLE)
    `GLGD_ASSERT_IMP(a_start_units_idle, mac_cmd0.start, !busy0 && !busy1)
    `GLGD_ASSERT_NXT(a_commit_loads_out, commit, out_valid_reg)
    `GLGD_ASSERT_IMP(a_lap_counted, out_valid_reg && lap_completed_reg, lap_count_reg != '0)

endmodule

// ----- tb/gps_lap_gate_detector_tb.sv -----
// Self-checking testbench of the GPS lap gate detector: directed words, register sweeps, random laps.
module gps_lap_gate_detector_tb
    import glgd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Word encodings of the action field.
    localparam logic ACT_FIX  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Fixed north gain, metres per latitude unit in Q2.30.
    localparam longint NORTH_GAIN = 64'd11952773;
    localparam int COURSE_WRAP  = 36000;
    localparam int HEADING_SPAN = 8000;

    // Run length guards. The limit covers ~2000 words, plus sender gaps, receiver
    // stalls and the long hold-off, several times over.
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 100;
    localparam int REPORT_CAP      = 40;

    typedef enum {RX_NONE, RX_LIGHT, RX_HEAVY} rx_style_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  action;
    logic signed [30:0]    latitude;
    logic signed [31:0]    longitude;
    logic [15:0]           course;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  lap_completed;
    logic [15:0]           lap_count;
    logic [31:0]           last_lap_ticks;
    logic [31:0]           elapsed_ticks;

    gps_lap_gate_detector u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .latitude       (latitude),
        .longitude      (longitude),
        .course         (course),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .lap_completed  (lap_completed),
        .lap_count      (lap_count),
        .last_lap_ticks (last_lap_ticks),
        .elapsed_ticks  (elapsed_ticks)
    );

    always #1ns clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the register file and of the lap state.
    // ------------------------------------------------------------------
    logic signed [30:0] home_lat_q;
    logic signed [31:0] home_lon_q;
    logic [15:0]        home_hdg_q;
    logic [23:0]        east_gain_q;
    logic signed [31:0] rot_cos_q;
    logic signed [31:0] rot_sin_q;
    logic [30:0]        gate_tol_q;
    logic [31:0]        min_lap_q;

    logic [15:0] laps_seen;
    logic [31:0] tick_timer;
    logic [31:0] last_lap_len;

    glgd_result_t lap_results_due[$];
    glgd_result_t want;

    int words_sent;
    int mismatches;
    int cycle_count;

    // Sender burst shaping and receiver stall shaping, retuned per test.
    int        burst_left;
    int        tx_gap_max;
    int        tx_burst_max;
    rx_style_t rx_style;
    bit        long_hold_req;
    int        hold_left;
    int        stall_run;
    logic      stall_level;

    // ------------------------------------------------------------------
    // Predict the result word of one input word and advance the lap state.
    // All geometry is carried in 128-bit signed so products never overflow;
    // an arithmetic shift of a signed value floors, as the block does.
    // ------------------------------------------------------------------
    function automatic glgd_result_t predict_lap_gate(input logic act,
                                                      input logic signed [30:0] lat,
                                                      input logic signed [31:0] lon,
                                                      input logic [15:0] crs);
        logic signed [127:0] dlat, dlon, gain, east_m, north_m, along, across, tol;
        int          course_cd;
        int          hdg_err;
        logic        near;
        glgd_result_t r;
        r.lap_completed = 1'b0;
        if (act == ACT_TICK)
        begin
            if (tick_timer != '1)
                tick_timer++;
        end
        else
        begin
            dlon = lon;
            dlon = dlon - home_lon_q;
            dlat = lat;
            dlat = dlat - home_lat_q;
            gain = east_gain_q;
            east_m = (dlon * gain) >>> 14;
            gain = NORTH_GAIN;
            north_m = (dlat * gain) >>> 14;
            along  = (east_m * rot_cos_q + north_m * rot_sin_q) >>> 30;
            across = (north_m * rot_cos_q - east_m * rot_sin_q) >>> 30;
            if (along < 0)
                along = -along;
            if (across < 0)
                across = -across;
            tol = gate_tol_q;
            course_cd = int'(crs) % COURSE_WRAP;
            hdg_err = course_cd - int'(home_hdg_q);
            if (hdg_err < 0)
                hdg_err = -hdg_err;
            near = (along <= tol) && (across <= tol) && (hdg_err <= HEADING_SPAN);
            if (near)
            begin
                // Near home: too early only restarts the timer, otherwise a lap.
                if (tick_timer >= min_lap_q)
                begin
                    if (laps_seen != '1)
                        laps_seen++;
                    last_lap_len = tick_timer;
                    r.lap_completed = 1'b1;
                end
                tick_timer = '0;
            end
        end
        r.lap_count      = laps_seen;
        r.last_lap_ticks = last_lap_len;
        r.elapsed_ticks  = tick_timer;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Register writes. Raise the write enable and leave it high across a
    // series; the caller drops it once after the last register.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_HOME_LAT: home_lat_q  = val[30:0];
            REG_HOME_LON: home_lon_q  = val;
            REG_HOME_HDG: home_hdg_q  = val[15:0];
            REG_EAST_SCL: east_gain_q = val[23:0];
            REG_ROT_COS:  rot_cos_q   = val;
            REG_ROT_SIN:  rot_sin_q   = val;
            REG_POS_TOL:  gate_tol_q  = val[30:0];
            REG_MIN_LAP:  min_lap_q   = val;
            default: ;
        endcase
    endtask

    task automatic load_setup(input logic [31:0] lat, input logic [31:0] lon,
                              input logic [31:0] hdg, input logic [31:0] east,
                              input logic [31:0] cosv, input logic [31:0] sinv,
                              input logic [31:0] tol, input logic [31:0] min_lap);
        write_reg(REG_HOME_LAT, lat);
        write_reg(REG_HOME_LON, lon);
        write_reg(REG_HOME_HDG, hdg);
        write_reg(REG_EAST_SCL, east);
        write_reg(REG_ROT_COS, cosv);
        write_reg(REG_ROT_SIN, sinv);
        write_reg(REG_POS_TOL, tol);
        write_reg(REG_MIN_LAP, min_lap);
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Offer one word, hold it until accepted, then record its expectation.
    // After the word, either stay in the burst or drop valid for a gap.
    // ------------------------------------------------------------------
    task automatic send_word(input logic act, input logic signed [30:0] lat,
                             input logic signed [31:0] lon, input logic [15:0] crs);
        int gap;
        in_valid  <= 1'b1;
        action    <= act;
        latitude  <= lat;
        longitude <= lon;
        course    <= crs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        lap_results_due.push_back(predict_lap_gate(act, lat, lon, crs));
        words_sent++;
        if (burst_left != 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, tx_burst_max);
            gap = $urandom_range(0, tx_gap_max);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid, wait for every result to come back, then let the block rest.
    task automatic settle();
        in_valid <= 1'b0;
        while (lap_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A tick carries random, ignored payload so every field bit toggles.
    task automatic send_tick();
        send_word(ACT_TICK, 31'($urandom()), 32'($urandom()), 16'($urandom()));
    endtask

    // Course close to the home heading (good) or beyond the 80 degree window.
    function automatic logic [15:0] pick_course(input bit good);
        int c;
        int off;
        if (good)
            off = int'($urandom_range(0, 2 * HEADING_SPAN)) - HEADING_SPAN;
        else
        begin
            off = int'($urandom_range(HEADING_SPAN + 1, 20000));
            if ($urandom_range(0, 1) == 0)
                off = -off;
        end
        c = int'(home_hdg_q) + off;
        if (c < 0)
            c += COURSE_WRAP;
        // Alias the course one turn up now and then; the block folds it back.
        if ($urandom_range(0, 3) == 0 && c + COURSE_WRAP <= 65535)
            c += COURSE_WRAP;
        return 16'(c);
    endfunction

    // Fix scattered around home by up to span units on each axis.
    task automatic send_near_fix(input int span, input bit good_heading);
        int dlat;
        int dlon;
        dlat = int'($urandom_range(0, 2 * span)) - span;
        dlon = int'($urandom_range(0, 2 * span)) - span;
        send_word(ACT_FIX, home_lat_q + 31'(dlat), home_lon_q + 32'(dlon),
                  pick_course(good_heading));
    endtask

    // Span in latitude units that keeps most near fixes inside the gate.
    function automatic int span_for_gate();
        longint s;
        s = longint'(gate_tol_q) / 900 + 2;
        if (s > 64'd536870912)
            s = 64'd536870912;
        return int'(s);
    endfunction

    // ------------------------------------------------------------------
    // Mixed traffic, mostly well-formed lap attempts: a run of ticks close
    // to the minimum lap time, then one or two fixes near home.
    // ------------------------------------------------------------------
    task automatic run_mixed(input int count);
        int  stop_at;
        int  pick;
        int  span;
        int  lo;
        int  hi;
        int  n;
        stop_at = words_sent + count;
        span = span_for_gate();
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                hi = (min_lap_q > 32'd37) ? 40 : int'(min_lap_q) + 3;
                lo = (hi > 6) ? hi - 6 : 0;
                n = $urandom_range(lo, hi);
                repeat (n) send_tick();
                send_near_fix(span, 1'b1);
                if ($urandom_range(0, 4) == 0)
                    send_near_fix(span, 1'b1);
            end
            else if (pick < 70)
                send_near_fix(span, 1'b0);
            else if (pick < 80)
                send_word(ACT_FIX, 31'($urandom()), 32'($urandom()), 16'($urandom()));
            else if (pick < 90)
                send_tick();
            else
                send_near_fix(span * 4 + 1, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic set_traffic(input int gap_max, input int burst_max, input rx_style_t style);
        tx_gap_max   = gap_max;
        tx_burst_max = burst_max;
        rx_style     = style;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Heading window edges, course folding, gate edges, early fix and laps,
    // all around the reset home point with a short minimum lap.
    task automatic test_directed_cases();
        set_traffic(2, 3, RX_LIGHT);
        // Reset values hold until here; the first fix is early under them.
        send_word(ACT_FIX, 31'sd0, 32'sd0, 16'd0);
        settle();
        load_setup(32'd0, 32'd0, 32'd0, 32'd11952773, 32'd1073741824, 32'd0,
                   32'd524288, 32'd2);
        send_tick();
        send_tick();
        send_word(ACT_FIX, 31'sd0, 32'sd0, 16'd8001);     // just outside heading window
        send_word(ACT_FIX, 31'sd0, 32'sd0, 16'd8000);     // window edge: lap
        send_tick();
        send_word(ACT_FIX, 31'sd0, 32'sd0, 16'd36000);    // folds to 0, early: clear
        send_tick();
        send_tick();
        send_word(ACT_FIX, 31'sd0, 32'sd0, 16'd65535);    // folds far from heading
        send_word(ACT_FIX, 31'h3FFFFFFF, 32'h7FFFFFFF, 16'd0);
        send_word(ACT_FIX, 31'h40000000, 32'h80000000, 16'd0);
        send_word(ACT_FIX, -31'sd1, -32'sd1, 16'd35999);  // near but heading off
        send_word(ACT_FIX, 31'sd700, 32'sd0, 16'd0);      // inside gate: lap
        send_tick();
        send_tick();
        send_word(ACT_FIX, 31'sd720, 32'sd0, 16'd0);      // just past gate north
        send_word(ACT_FIX, -31'sd719, 32'sd0, 16'd0);     // just past gate south
        send_word(ACT_FIX, 31'sd0, -32'sd718, 16'd0);     // inside gate west: lap
        settle();
    endtask

    // Register corners: zero gate, zero east scale, raw out-of-range values,
    // headings above one turn, and the minimum lap time at both ends.
    task automatic test_register_extremes();
        set_traffic(4, 6, RX_HEAVY);
        load_setup(32'd9000, 32'd0, 32'd9000, 32'd9000000, 32'd0, 32'd1073741824,
                   32'd1048576, 32'd5);
        run_mixed(80);
        settle();
        load_setup(32'd900000000, -32'd1800000000, 32'd35999, 32'd0, -32'd1073741824,
                   -32'd1073741824, 32'd0, 32'd0);
        run_mixed(80);
        settle();
        load_setup(32'h40000000, 32'h7FFFFFFF, 32'd65535, 32'hFFFFFF, 32'h80000000,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
        run_mixed(80);
        settle();
        // Heading written above one turn: only courses from 320 degrees pass.
        load_setup(-32'd900000000, 32'd1800000000, 32'd40000, 32'd11952773, 32'd1073741824,
                   32'd0, 32'h7FFFFFFF, 32'd1);
        run_mixed(80);
        settle();
    endtask

    // Hold the output for a long stretch while words keep coming, so the
    // block fills and must stall its input.
    task automatic test_output_backpressure();
        set_traffic(0, 0, RX_NONE);
        load_setup(32'd123456789, -32'd45678901, 32'd18000, 32'd8000000, -32'd1073741824,
                   32'd0, 32'd262144, 32'd3);
        long_hold_req = 1'b1;
        run_mixed(60);
        settle();
    endtask

    // Random home points and headings with matching rotation, varied gates
    // and minimum lap times, under varied traffic shapes.
    task automatic test_random_laps();
        real  theta;
        int   hdg;
        for (int round = 0; round < 6; round++)
        begin
            case (round % 3)
                0: set_traffic(0, 0, RX_NONE);
                1: set_traffic(3, 8, RX_LIGHT);
                default: set_traffic(8, 4, RX_HEAVY);
            endcase
            hdg = $urandom_range(0, COURSE_WRAP - 1);
            theta = real'(hdg) * 3.14159265358979 / 18000.0;
            load_setup(32'(int'($urandom_range(0, 1800000000)) - 900000000),
                       32'($urandom()),
                       32'(hdg),
                       32'($urandom_range(0, 11952773)),
                       32'(int'($cos(theta) * 1073741824.0)),
                       32'(int'($sin(theta) * 1073741824.0)),
                       32'($urandom_range(131072, 4194304)),
                       32'($urandom_range(0, 30)));
            run_mixed(260);
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall in random runs per style; a requested hold-off keeps
    // stall high while hold_left counts down from LONG_HOLD.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_run != 0)
            stall_run--;
        else
        begin
            case (rx_style)
                RX_NONE:
                begin
                    stall_level = 1'b0;
                    stall_run = 16;
                end
                RX_LIGHT:
                begin
                    stall_level = ($urandom_range(0, 3) == 0);
                    stall_run = $urandom_range(0, 3);
                end
                default:
                begin
                    stall_level = ($urandom_range(0, 1) == 0);
                    stall_run = $urandom_range(0, 12);
                end
            endcase
            out_stall <= stall_level;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: pop the oldest expectation on every accepted result.
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string field, input longint exp_v, input longint act_v);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (lap_results_due.size() == 0)
                flag_mismatch("unexpected result, lap_count", -1, lap_count);
            else
            begin
                want = lap_results_due.pop_front();
                if (lap_completed !== want.lap_completed)
                    flag_mismatch("lap_completed", want.lap_completed, lap_completed);
                if (lap_count !== want.lap_count)
                    flag_mismatch("lap_count", want.lap_count, lap_count);
                if (last_lap_ticks !== want.last_lap_ticks)
                    flag_mismatch("last_lap_ticks", want.last_lap_ticks, last_lap_ticks);
                if (elapsed_ticks !== want.elapsed_ticks)
                    flag_mismatch("elapsed_ticks", want.elapsed_ticks, elapsed_ticks);
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset once, run each test, drain, report.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        action    <= ACT_FIX;
        latitude  <= '0;
        longitude <= '0;
        course    <= '0;
        home_lat_q   = '0;
        home_lon_q   = '0;
        home_hdg_q   = '0;
        east_gain_q  = 24'd11952773;
        rot_cos_q    = 32'sd1073741824;
        rot_sin_q    = '0;
        gate_tol_q   = 31'd524288;
        min_lap_q    = 32'd10;
        laps_seen    = '0;
        tick_timer   = '0;
        last_lap_len = '0;
        words_sent   = 0;
        mismatches   = 0;
        cycle_count  = 0;
        burst_left   = 0;
        hold_left    = 0;
        stall_run    = 0;
        long_hold_req = 1'b0;
        set_traffic(0, 0, RX_NONE);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_register_extremes();
        test_output_backpressure();
        test_random_laps();

        // Catch any stray result after the last expected one.
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && lap_results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/glgd_pkg.sv
hdl/glgd_mac.sv
hdl/glgd_lap.sv
hdl/gps_lap_gate_detector.sv
tb/gps_lap_gate_detector_tb.sv
